// ===== hw/rtl/iln_pkg.sv =====
// ----------------------------------------------------------------------------
// iln_pkg
// Shared types and constants of the identifier list normalizer.
// ----------------------------------------------------------------------------
package iln_pkg;

    // Longest name, in characters, and the width of the length counter
    localparam int MAX_NAME_LEN = 63;
    localparam int NAME_LEN_W   = $clog2(MAX_NAME_LEN + 1);

    // Depth of the work queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Characters with a role in the syntax
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    typedef enum logic [2:0] {
        PH_EXPECT,
        PH_UNQUOTED,
        PH_QUOTED,
        PH_QPEND,
        PH_AFTER
    } phase_t;

    // Results caused by one input beat: an optional separating comma,
    // an optional name character, and an optional closing verdict.
    typedef struct packed {
        logic       emit_comma;
        logic       emit_char;
        logic [7:0] ch;
        logic       emit_done;
        logic       verdict;
    } iln_work_t;

    typedef struct packed {
        logic empty;
        logic full;
    } iln_qstat_t;

endpackage

// ===== hw/rtl/iln_front.sv =====
// ----------------------------------------------------------------------------
// iln_front
// Parser state machine: classify each byte and build a work entry.
// ----------------------------------------------------------------------------
module iln_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        byte_value,
    input  logic              byte_present,
    input  logic              end_of_value,
    output logic              work_valid,
    output iln_pkg::iln_work_t work
);
    import iln_pkg::*;

    phase_t                phase_reg, phase_next, phase_mid;
    logic                  dq_reg, dq_next, dq_mid;
    logic [NAME_LEN_W-1:0] len_reg, len_next, len_mid;
    logic                  first_reg, first_next, first_mid;
    logic                  rej_reg, rej_next, rej_mid;

    logic       act;
    logic       is_space, is_alpha, is_ident, is_quote, is_start, is_q, len_full;
    logic [7:0] q_char;

    assign act      = byte_present && !rej_reg;
    assign is_space = byte_value inside {8'd32, [8'd9:8'd13]};
    assign is_alpha = byte_value inside {[8'd65:8'd90], [8'd97:8'd122]};
    assign is_ident = is_alpha || (byte_value inside {[8'd48:8'd57], CH_UNDER, CH_DOLLAR});
    assign is_quote = (byte_value == CH_SQUOTE) || (byte_value == CH_DQUOTE);
    assign is_start = is_quote || is_alpha || (byte_value inside {CH_UNDER, CH_DOLLAR});
    assign q_char   = dq_reg ? CH_DQUOTE : CH_SQUOTE;
    assign is_q     = (byte_value == q_char);
    assign len_full = (len_reg >= NAME_LEN_W'(MAX_NAME_LEN));

    // Next state
    always_comb
    begin
        phase_mid = phase_reg;
        dq_mid    = dq_reg;
        len_mid   = len_reg;
        first_mid = first_reg;
        rej_mid   = rej_reg;
        if (act)
        begin
            case (phase_reg)
                PH_EXPECT:
                begin
                    if (is_space)
                    begin
                        phase_mid = PH_EXPECT;
                    end
                    else if (is_start)
                    begin
                        first_mid = 1'b0;
                        if (is_quote)
                        begin
                            dq_mid    = (byte_value == CH_DQUOTE);
                            len_mid   = '0;
                            phase_mid = PH_QUOTED;
                        end
                        else
                        begin
                            len_mid   = NAME_LEN_W'(1);
                            phase_mid = PH_UNQUOTED;
                        end
                    end
                    else
                    begin
                        rej_mid = 1'b1;
                    end
                end
                PH_UNQUOTED:
                begin
                    if (byte_value == CH_COMMA)
                        phase_mid = PH_EXPECT;
                    else if (is_space)
                        phase_mid = PH_AFTER;
                    else if (is_ident && !len_full)
                        len_mid = len_reg + NAME_LEN_W'(1);
                    else
                        rej_mid = 1'b1;
                end
                PH_QUOTED:
                begin
                    if (is_q)
                        phase_mid = PH_QPEND;
                    else if (!len_full)
                        len_mid = len_reg + NAME_LEN_W'(1);
                    else
                        rej_mid = 1'b1;
                end
                PH_QPEND, PH_AFTER:
                begin
                    if ((phase_reg == PH_QPEND) && is_q)
                    begin
                        // doubled quote: one character of the name
                        phase_mid = PH_QUOTED;
                        if (!len_full)
                            len_mid = len_reg + NAME_LEN_W'(1);
                        else
                            rej_mid = 1'b1;
                    end
                    else if (is_space)
                        phase_mid = PH_AFTER;
                    else if (byte_value == CH_COMMA)
                        phase_mid = PH_EXPECT;
                    else
                        rej_mid = 1'b1;
                end
                default:
                begin
                    rej_mid = 1'b1;
                end
            endcase
        end

        if (end_of_value)
        begin
            phase_next = PH_EXPECT;
            dq_next    = 1'b0;
            len_next   = '0;
            first_next = 1'b1;
            rej_next   = 1'b0;
        end
        else
        begin
            phase_next = phase_mid;
            dq_next    = dq_mid;
            len_next   = len_mid;
            first_next = first_mid;
            rej_next   = rej_mid;
        end
    end

    // Outputs: the work entry of this beat
    always_comb
    begin
        work.emit_comma = 1'b0;
        work.emit_char  = 1'b0;
        work.ch         = byte_value;
        work.emit_done  = end_of_value;
        work.verdict    = !(rej_mid || (phase_mid == PH_QUOTED));
        if (act)
        begin
            case (phase_reg)
                PH_EXPECT:
                begin
                    if (!is_space && is_start)
                    begin
                        work.emit_comma = !first_reg;
                        work.emit_char  = 1'b1;
                    end
                end
                PH_UNQUOTED:
                begin
                    work.emit_char = (byte_value != CH_COMMA) && !is_space && is_ident
                                     && !len_full;
                end
                PH_QUOTED:
                begin
                    work.emit_char = is_q || !len_full;
                end
                PH_QPEND:
                begin
                    work.emit_char = is_q && !len_full;
                end
                default:
                begin
                    work.emit_char = 1'b0;
                end
            endcase
        end
        work_valid = work.emit_comma || work.emit_char || work.emit_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EXPECT;
            dq_reg    <= 1'b0;
            len_reg   <= '0;
            first_reg <= 1'b1;
            rej_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            dq_reg    <= dq_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            rej_reg   <= rej_next;
        end
    end

endmodule

// ===== hw/rtl/iln_queue.sv =====
// ----------------------------------------------------------------------------
// iln_queue
// Short work queue that decouples the parser from the result serializer.
// ----------------------------------------------------------------------------
module iln_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  iln_pkg::iln_work_t wr_data,
    input  logic               rd_en,
    output iln_pkg::iln_work_t rd_data,
    output iln_pkg::iln_qstat_t stat
);
    import iln_pkg::*;

    iln_work_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/iln_back.sv =====
// ----------------------------------------------------------------------------
// iln_back
// Result serializer: split each work entry into result beats.
// ----------------------------------------------------------------------------
module iln_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  iln_pkg::iln_work_t head,
    output logic               head_take,
    input  logic               pop,
    output logic               empty,
    output logic               char_present,
    output logic [7:0]         out_char,
    output logic               value_done,
    output logic               accepted,
    output logic               last_of_run
);
    import iln_pkg::*;

    // bit 0 comma, bit 1 character, bit 2 verdict
    logic [2:0] used_reg, used_next;
    logic [2:0] left, pick;
    logic       load, is_last;
    logic       out_valid_reg, out_valid_next;
    logic       present_reg, done_reg, acc_reg, last_reg;
    logic [7:0] char_reg;

    assign left    = {head.emit_done, head.emit_char, head.emit_comma} & ~used_reg;
    assign pick    = left & (~left + 3'd1);
    assign is_last = ((left & ~pick) == 3'd0);
    assign load    = head_valid && (!out_valid_reg || pop);
    assign head_take = load && is_last;

    always_comb
    begin
        used_next = used_reg;
        if (load)
            used_next = is_last ? 3'd0 : (used_reg | pick);
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold until the next beat loads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            present_reg <= !pick[2];
            char_reg    <= pick[0] ? CH_COMMA : (pick[1] ? head.ch : 8'd0);
            done_reg    <= pick[2];
            acc_reg     <= pick[2] && head.verdict;
            last_reg    <= is_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign char_present = present_reg;
    assign out_char     = char_reg;
    assign value_done   = done_reg;
    assign accepted     = acc_reg;
    assign last_of_run  = last_reg;

endmodule

// ===== hw/rtl/identifier_list_normalizer.sv =====
// ----------------------------------------------------------------------------
// identifier_list_normalizer
// Checks a comma-separated list of plain or quoted names and re-emits it
// without whitespace; the closing beat of each value carries the verdict.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake    | Beat contents
//  ---------+--------------+------------------------------------------------
//  input    | push / full  | byte_value, byte_present, end_of_value
//  result   | pop / empty  | char_present, out_char, value_done, accepted,
//           |              | last_of_run
//
// One input beat is taken every cycle while full is low; the parser updates
// its state in that same cycle. Each beat yields zero to three result beats,
// and the output register drains one result per cycle while pop is high,
// so sustained input rate is one beat per cycle whenever beats average one
// result or fewer; each result passes through work queue and output register.
// Reset (rst_n low) clears parser state, work queue and output register.
// A stalled consumer fills the four-entry work queue, then full rises.
module identifier_list_normalizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] byte_value,
    input  logic       byte_present,
    input  logic       end_of_value,
    input  logic       pop,
    output logic       empty,
    output logic       char_present,
    output logic [7:0] out_char,
    output logic       value_done,
    output logic       accepted,
    output logic       last_of_run
);
    import iln_pkg::*;

    logic       take;
    logic       work_valid;
    iln_work_t  work;
    iln_work_t  head;
    iln_qstat_t qstat;
    logic       head_take;

    // Accept a beat whenever the work queue has room
    assign full = qstat.full;
    assign take = push && !qstat.full;

    // Front: parse and classify
    iln_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .byte_value   (byte_value),
        .byte_present (byte_present),
        .end_of_value (end_of_value),
        .work_valid   (work_valid),
        .work         (work)
    );

    // Queue: hold work entries; beats that emit nothing are dropped here
    iln_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take && work_valid),
        .wr_data (work),
        .rd_en   (head_take),
        .rd_data (head),
        .stat    (qstat)
    );

    // Back: serialize each entry into result beats
    iln_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!qstat.empty),
        .head         (head),
        .head_take    (head_take),
        .pop          (pop),
        .empty        (empty),
        .char_present (char_present),
        .out_char     (out_char),
        .value_done   (value_done),
        .accepted     (accepted),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== hw/rtl/iln_checker.sv =====
// ----------------------------------------------------------------------------
// iln_checker
// Port-level checks of the identifier list normalizer, bound to the top.
// ----------------------------------------------------------------------------
module iln_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       end_of_value,
    input logic       pop,
    input logic       empty,
    input logic       char_present,
    input logic [7:0] out_char,
    input logic       value_done,
    input logic       accepted,
    input logic       last_of_run
);

    // A waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_char) && $stable(char_present)
        && $stable(value_done) && $stable(accepted) && $stable(last_of_run))
        else $error("result changed while stalled");

    // The closing beat of a value is the last of its input beat
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && value_done |-> last_of_run && !char_present)
        else $error("closing beat not last of its run");

    // Verdict appears only on a closing beat
    a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && accepted |-> value_done)
        else $error("verdict on a character beat");

    // An accepted end of value always reaches the result side
    a_end_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && end_of_value |=> ##1 !empty)
        else $error("end of value produced no result");

endmodule

bind identifier_list_normalizer iln_checker u_iln_checker (.*);

// ===== verif/iln_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iln_result_checker
// Watches both channels of the identifier list normalizer, tracks the parser
// state for every accepted input beat and compares each popped result beat
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module iln_result_checker
    import iln_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] byte_value,
    input  logic       byte_present,
    input  logic       end_of_value,
    input  logic       pop,
    input  logic       empty,
    input  logic       char_present,
    input  logic [7:0] out_char,
    input  logic       value_done,
    input  logic       accepted,
    input  logic       last_of_run,
    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        logic       char_present;
        logic [7:0] out_char;
        logic       value_done;
        logic       accepted;
        logic       last_of_run;
    } result_beat_t;

    result_beat_t expected_results[$];
    int           fail_count = 0;

    // Parser state mirror
    phase_t     ph;
    logic       quote_dq;
    logic [6:0] name_len;
    logic       first_pending;
    logic       rejected;

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic reset_parser();
        ph            = PH_EXPECT;
        quote_dq      = 1'b0;
        name_len      = '0;
        first_pending = 1'b1;
        rejected      = 1'b0;
    endtask

    task automatic add_result(input logic cp, input logic [7:0] ch, input logic done,
                              input logic acc);
        result_beat_t r;
        r = '{char_present: cp, out_char: ch, value_done: done, accepted: acc,
              last_of_run: 1'b0};
        expected_results.push_back(r);
    endtask

    // Count one name character; past the limit the value is rejected.
    task automatic take_name_char(input logic [7:0] c);
        if (name_len >= MAX_NAME_LEN)
        begin
            rejected = 1'b1;
        end
        else
        begin
            name_len = name_len + 1'b1;
            add_result(1'b1, c, 1'b0, 1'b0);
        end
    endtask

    // Byte after a closed name: whitespace, comma, or garbage.
    task automatic close_name(input logic [7:0] c);
        if (is_space(c))
            ph = PH_AFTER;
        else if (c == CH_COMMA)
            ph = PH_EXPECT;
        else
            rejected = 1'b1;
    endtask

    task automatic predict_normalized(input logic [7:0] c, input logic present,
                                      input logic fin);
        logic [7:0]   q;
        int           base;
        result_beat_t r;
        base = expected_results.size();
        if (present && !rejected)
        begin
            q = quote_dq ? CH_DQUOTE : CH_SQUOTE;
            case (ph)
                PH_EXPECT:
                begin
                    if (c == CH_SQUOTE || c == CH_DQUOTE || is_alpha(c) ||
                        c == CH_UNDER || c == CH_DOLLAR)
                    begin
                        if (!first_pending)
                            add_result(1'b1, CH_COMMA, 1'b0, 1'b0);
                        first_pending = 1'b0;
                        add_result(1'b1, c, 1'b0, 1'b0);
                        if (c == CH_SQUOTE || c == CH_DQUOTE)
                        begin
                            quote_dq = (c == CH_DQUOTE);
                            name_len = '0;
                            ph       = PH_QUOTED;
                        end
                        else
                        begin
                            name_len = 7'd1;
                            ph       = PH_UNQUOTED;
                        end
                    end
                    else if (!is_space(c))
                    begin
                        rejected = 1'b1;
                    end
                end
                PH_UNQUOTED:
                begin
                    if (c == CH_COMMA)
                        ph = PH_EXPECT;
                    else if (is_space(c))
                        ph = PH_AFTER;
                    else if (is_alpha(c) || (c >= "0" && c <= "9") ||
                             c == CH_UNDER || c == CH_DOLLAR)
                        take_name_char(c);
                    else
                        rejected = 1'b1;
                end
                PH_QUOTED:
                begin
                    if (c == q)
                    begin
                        ph = PH_QPEND;
                        add_result(1'b1, c, 1'b0, 1'b0);
                    end
                    else
                    begin
                        take_name_char(c);
                    end
                end
                PH_QPEND:
                begin
                    if (c == q)
                    begin
                        ph = PH_QUOTED;
                        take_name_char(c);
                    end
                    else
                    begin
                        close_name(c);
                    end
                end
                PH_AFTER:
                    close_name(c);
                default:
                    rejected = 1'b1;
            endcase
        end
        if (fin)
        begin
            if (ph == PH_QUOTED)
                rejected = 1'b1;
            add_result(1'b0, 8'h00, 1'b1, !rejected);
            reset_parser();
        end
        // Tag the last result of this beat
        if (expected_results.size() > base)
        begin
            r = expected_results.pop_back();
            r.last_of_run = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic report_field(input string field, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_beat_t exp_beat;
        if (!rst_n)
        begin
            reset_parser();
            expected_results.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (push && !full)
                predict_normalized(byte_value, byte_present, end_of_value);
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: result beat with none expected: expected nothing, ",
                              "actual %0h/%0h/%0h/%0h/%0h"},
                             $time, char_present, out_char, value_done, accepted,
                             last_of_run);
                end
                else
                begin
                    exp_beat = expected_results.pop_front();
                    report_field("char_present", 8'(exp_beat.char_present),
                                 8'(char_present));
                    report_field("out_char", exp_beat.out_char, out_char);
                    report_field("value_done", 8'(exp_beat.value_done), 8'(value_done));
                    report_field("accepted", 8'(exp_beat.accepted), 8'(accepted));
                    report_field("last_of_run", 8'(exp_beat.last_of_run),
                                 8'(last_of_run));
                end
            end
            outstanding <= expected_results.size();
            mismatches  <= fail_count;
        end
    end

endmodule

// ===== verif/identifier_list_normalizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// identifier_list_normalizer_tb
// Feeds comma-separated name lists into the normalizer one byte per beat,
// first a handful of hand-picked values, then randomly built lists with
// occasional corruption, under random idling on both channels. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module identifier_list_normalizer_tb;
    import iln_pkg::*;

    localparam int CLK_HALF_NS   = 10;
    localparam int RANDOM_BEATS  = 260;
    localparam int RX_LONG_HOLD  = 200;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef enum int {
        NAME_PLAIN,
        NAME_SQUOTED,
        NAME_DQUOTED
    } name_style_t;

    // Every block input starts at a known value
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       push         = 1'b0;
    logic [7:0] byte_value   = 8'h00;
    logic       byte_present = 1'b0;
    logic       end_of_value = 1'b0;
    logic       pop          = 1'b0;
    logic       full;
    logic       empty;
    logic       char_present;
    logic [7:0] out_char;
    logic       value_done;
    logic       accepted;
    logic       last_of_run;
    int         mismatches;
    int         outstanding;

    // Sender and receiver pacing
    int         tx_fast_left  = 0;
    int         rx_fast_left  = 0;
    bit         rx_hold_req   = 1'b0;
    int         offered_beats = 0;

    // Bytes of the value under construction
    logic [7:0] value_bytes[$];

    identifier_list_normalizer u_dut (.*);

    iln_result_checker u_checker (.*);

    always #(CLK_HALF_NS) clk = ~clk;

    // Watchdog: end the run if the handshakes hang
    initial
    begin
        #(TIMEOUT_NS);
        $display("identifier_list_normalizer_tb: FAIL");
        $finish;
    end

    // Half the beats go without delay, the rest wait a randomly drawn gap.
    function automatic int draw_gap();
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0A;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    // Legal character of a plain name; a lead character is never a digit.
    function automatic logic [7:0] pick_name_char(input bit lead);
        case ($urandom_range(0, lead ? 3 : 4))
            0:       return 8'($urandom_range(65, 90));
            1:       return 8'($urandom_range(97, 122));
            2:       return lead ? CH_DOLLAR : CH_UNDER;
            3:       return lead ? CH_UNDER : CH_DOLLAR;
            default: return 8'($urandom_range(48, 57));
        endcase
    endfunction

    // Append one name of len characters; a quote inside quotes is doubled.
    task automatic add_name(input int len, input name_style_t style);
        logic [7:0] q;
        logic [7:0] ch;
        if (style == NAME_PLAIN)
        begin
            value_bytes.push_back(pick_name_char(1'b1));
            for (int i = 1; i < len; i++)
                value_bytes.push_back(pick_name_char(1'b0));
        end
        else
        begin
            q = (style == NAME_DQUOTED) ? CH_DQUOTE : CH_SQUOTE;
            value_bytes.push_back(q);
            for (int i = 0; i < len; i++)
            begin
                ch = ($urandom_range(0, 7) == 0) ? q : 8'($urandom_range(0, 255));
                value_bytes.push_back(ch);
                if (ch == q)
                    value_bytes.push_back(q);
            end
            value_bytes.push_back(q);
        end
    endtask

    // Offer one beat and hold it until the block takes it. Push stays high
    // across back-to-back beats so it never gets two updates in one step.
    task automatic send_beat(input logic [7:0] b, input logic present, input logic fin);
        int gap;
        if (tx_fast_left > 0)
        begin
            tx_fast_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 24) == 0)
                tx_fast_left = $urandom_range(8, 40);
            gap = draw_gap();
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        byte_value   <= b;
        byte_present <= present;
        end_of_value <= fin;
        do
            @(posedge clk);
        while (full);
        if (present || fin)
            offered_beats++;
    endtask

    // Drop push and wait for every predicted result beat to drain.
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver: pop with random gaps; on request hold off for a long stretch
    // so the work queue fills and full rises.
    initial
    begin : receiver
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            if (rx_fast_left > 0)
            begin
                rx_fast_left--;
                gap = 0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    rx_fast_left = $urandom_range(8, 40);
                gap = draw_gap();
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    initial
    begin : stimulus
        int          value_idx;
        int          n_names;
        int          long_len;
        int          pos;
        name_style_t long_style;
        name_style_t style;
        bit          end_alone;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed values ----
        // Beat with neither byte nor end: nothing comes out
        send_beat(8'hFF, 1'b0, 1'b0);
        // Empty value: only the accepting close
        send_beat(8'h00, 1'b0, 1'b1);
        // Leading dollar, quoted name made of one doubled quote, trailing
        // comma after whitespace, end on a beat of its own
        send_beat(CH_DOLLAR, 1'b1, 1'b0);
        send_beat("u", 1'b1, 1'b0);
        send_beat(CH_COMMA, 1'b1, 1'b0);
        send_beat(CH_DQUOTE, 1'b1, 1'b0);
        send_beat(CH_DQUOTE, 1'b1, 1'b0);
        send_beat(CH_DQUOTE, 1'b1, 1'b0);
        send_beat(CH_DQUOTE, 1'b1, 1'b0);
        send_beat(8'h20, 1'b1, 1'b0);
        send_beat(CH_COMMA, 1'b1, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b1);
        // Zero byte where a name should start: rejected, rest ignored
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        // Quote left open at end of value; high byte counts as a character
        send_beat(CH_SQUOTE, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b1);
        // Text after a name without a comma
        send_beat(CH_UNDER, 1'b1, 1'b0);
        send_beat("9", 1'b1, 1'b0);
        send_beat(8'h09, 1'b1, 1'b0);
        send_beat("Z", 1'b1, 1'b1);
        // Empty name before a comma
        send_beat(CH_COMMA, 1'b1, 1'b0);
        send_beat("x", 1'b1, 1'b1);
        // Name starting with a digit
        send_beat("1", 1'b1, 1'b1);

        // ---- Random values ----
        offered_beats = 0;
        value_idx     = 0;
        while (offered_beats < RANDOM_BEATS)
        begin
            // Stall the receiver while the sender streams without gaps
            if (value_idx == 2)
            begin
                rx_hold_req  = 1'b1;
                tx_fast_left = 60;
            end
            // Let everything drain once in the middle of the run
            if (value_idx == 4)
                wait_for_drain();
            if ($urandom_range(0, 14) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);

            // The first two values carry a name around the length limit, plain
            // and quoted; later ones only rarely.
            long_len   = 0;
            long_style = NAME_PLAIN;
            if (value_idx < 2)
            begin
                long_len   = $urandom_range(62, 65);
                long_style = (value_idx == 0) ? NAME_PLAIN :
                             ($urandom_range(0, 1) ? NAME_SQUOTED : NAME_DQUOTED);
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                long_len   = $urandom_range(60, 66);
                long_style = name_style_t'($urandom_range(0, 2));
            end

            // Build a well-formed list first
            value_bytes.delete();
            n_names = $urandom_range(0, 4);
            if (long_len > 0 && n_names == 0)
                n_names = 1;
            if ($urandom_range(0, 3) == 0)
                value_bytes.push_back(pick_space());
            for (int k = 0; k < n_names; k++)
            begin
                if (k > 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                        value_bytes.push_back(pick_space());
                    value_bytes.push_back(CH_COMMA);
                    if ($urandom_range(0, 2) == 0)
                        value_bytes.push_back(pick_space());
                end
                if (k == 0 && long_len > 0)
                begin
                    add_name(long_len, long_style);
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0:       style = NAME_SQUOTED;
                        1:       style = NAME_DQUOTED;
                        default: style = NAME_PLAIN;
                    endcase
                    add_name(style == NAME_PLAIN ? $urandom_range(1, 6) :
                             $urandom_range(0, 6), style);
                end
            end
            case ($urandom_range(0, 5))
                0:       value_bytes.push_back(pick_space());
                1:       value_bytes.push_back(CH_COMMA);
                2:
                begin
                    value_bytes.push_back(CH_COMMA);
                    value_bytes.push_back(pick_space());
                end
                default: ;
            endcase

            // Then break some of them; leave long names intact so the
            // length limit itself decides the verdict
            if (long_len == 0)
            begin
                pos = $urandom_range(0, value_bytes.size());
                case ($urandom_range(0, 11))
                    0:
                        if (value_bytes.size() > 0)
                            value_bytes[$urandom_range(0, value_bytes.size() - 1)] =
                                8'($urandom_range(0, 255));
                    1:       value_bytes.insert(pos, 8'($urandom_range(0, 255)));
                    2:       value_bytes.insert(pos, CH_COMMA);
                    3:
                        while (value_bytes.size() > pos)
                            void'(value_bytes.pop_back());
                    4:
                    begin
                        value_bytes.delete();
                        repeat ($urandom_range(1, 8))
                            value_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase
            end

            // Send it; close either on the last byte or with an end-only beat
            end_alone = (value_bytes.size() == 0) || ($urandom_range(0, 2) == 0);
            foreach (value_bytes[i])
                send_beat(value_bytes[i], 1'b1,
                          !end_alone && (i == value_bytes.size() - 1));
            if (end_alone)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            value_idx++;
        end

        // Drain, settle, and give the verdict
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("identifier_list_normalizer_tb: PASS");
        else
            $display("identifier_list_normalizer_tb: FAIL");
        $finish;
    end

endmodule

// ===== identifier_list_normalizer.f =====
hw/rtl/iln_pkg.sv
hw/rtl/iln_front.sv
hw/rtl/iln_queue.sv
hw/rtl/iln_back.sv
hw/rtl/identifier_list_normalizer.sv
hw/rtl/iln_checker.sv
verif/iln_result_checker.sv
verif/identifier_list_normalizer_tb.sv
